### sv/lcan_pkg.sv
`default_nettype none
package lcan_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_MEASURE   = 2'd1,
    OP_TRANSFORM = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_FIN
  } state_t;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS = 17;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CONTRAST = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMBIENT_RED = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMBIENT_GREEN = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMBIENT_BLUE = 8'd3;

  localparam logic [15:0] CONTRAST_RESET = 16'd26214;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam int NUM_LANES = 3;
  localparam int QUOT_BITS = 16;

  typedef struct packed {
    logic [15:0] contrast;
    logic [NUM_LANES-1:0][16:0] ambient;
  } cfg_t;

endpackage
`default_nettype wire

### sv/lcan_if.sv
`default_nettype none
interface lcan_in_if;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic texel_valid;
  logic [23:0] red_in;
  logic [23:0] green_in;
  logic [23:0] blue_in;

  modport source(output valid, operation, texel_valid, red_in, green_in, blue_in,
                 input ready);
  modport sink(input valid, operation, texel_valid, red_in, green_in, blue_in,
               output ready);
endinterface

interface lcan_out_if;
  logic valid;
  logic ready;
  logic [16:0] red_out;
  logic [16:0] green_out;
  logic [16:0] blue_out;

  modport source(output valid, red_out, green_out, blue_out, input ready);
  modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface
`default_nettype wire

### sv/lcan_fifo.sv
`default_nettype none
module lcan_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  avail,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### sv/lcan_front.sv
`default_nettype none
module lcan_front #(
  parameter int TEXEL_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  lcan_in_if.sink                    in_ch,
  input  wire logic                  full,
  output logic                       push,
  output logic [6*TEXEL_BITS-1:0]    push_data
);

  logic [TEXEL_BITS-1:0] max_val [lcan_pkg::NUM_LANES];
  logic [TEXEL_BITS-1:0] min_val [lcan_pkg::NUM_LANES];
  logic [TEXEL_BITS-1:0] tex [lcan_pkg::NUM_LANES];
  logic [TEXEL_BITS-1:0] rng [lcan_pkg::NUM_LANES];
  logic                  accept;
  lcan_pkg::op_t         op;

  assign in_ch.ready = !full;
  assign accept = in_ch.valid && in_ch.ready;
  assign op = lcan_pkg::op_t'(in_ch.operation);

  assign tex[0] = TEXEL_BITS'(in_ch.red_in);
  assign tex[1] = TEXEL_BITS'(in_ch.green_in);
  assign tex[2] = TEXEL_BITS'(in_ch.blue_in);

  always_comb begin
    for (int i = 0; i < lcan_pkg::NUM_LANES; i++) begin
      rng[i] = (max_val[i] > min_val[i]) ? (max_val[i] - min_val[i]) : '0;
      push_data[2*i*TEXEL_BITS +: TEXEL_BITS] = rng[i];
      push_data[(2*i+1)*TEXEL_BITS +: TEXEL_BITS] = tex[i];
    end
  end

  assign push = accept && in_ch.texel_valid && (op == lcan_pkg::OP_TRANSFORM);

  always_ff @(posedge clk) begin
    if (rst || (accept && (op == lcan_pkg::OP_CLEAR))) begin
      for (int i = 0; i < lcan_pkg::NUM_LANES; i++) begin
        max_val[i] <= '0;
        min_val[i] <= '1;
      end
    end else if (accept && in_ch.texel_valid && (op == lcan_pkg::OP_MEASURE)) begin
      for (int i = 0; i < lcan_pkg::NUM_LANES; i++) begin
        if (tex[i] > max_val[i]) begin
          max_val[i] <= tex[i];
        end
        if (tex[i] < min_val[i]) begin
          min_val[i] <= tex[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

### sv/lcan_back.sv
`default_nettype none
module lcan_back #(
  parameter int TEXEL_BITS = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire lcan_pkg::cfg_t           cfg,
  input  wire logic                     avail,
  input  wire logic [6*TEXEL_BITS-1:0]  pop_data,
  output logic                          pop,
  lcan_out_if.source                    out_ch
);

  localparam int SW = ((TEXEL_BITS > 16) ? TEXEL_BITS : 16) + 16;
  localparam int RW = SW + 1;
  localparam int CW = $clog2(lcan_pkg::QUOT_BITS);

  lcan_pkg::state_t state;
  lcan_pkg::state_t state_next;

  logic [TEXEL_BITS-1:0]          tex [lcan_pkg::NUM_LANES];
  logic [TEXEL_BITS-1:0]          rng [lcan_pkg::NUM_LANES];
  logic [SW-1:0]                  scale [lcan_pkg::NUM_LANES];
  logic [RW-1:0]                  rem [lcan_pkg::NUM_LANES];
  logic [lcan_pkg::QUOT_BITS-1:0] quot [lcan_pkg::NUM_LANES];
  logic [lcan_pkg::NUM_LANES-1:0] sat;
  logic [CW-1:0]                  cnt;
  logic [16:0]                    result [lcan_pkg::NUM_LANES];
  logic                           out_valid;
  logic                           load_out;

  logic [TEXEL_BITS+15:0]         prod [lcan_pkg::NUM_LANES];
  logic [RW-1:0]                  shifted [lcan_pkg::NUM_LANES];
  logic [RW-1:0]                  rem2 [lcan_pkg::NUM_LANES];
  logic [16:0]                    amb [lcan_pkg::NUM_LANES];
  logic [32:0]                    blend [lcan_pkg::NUM_LANES];
  logic [16:0]                    shade [lcan_pkg::NUM_LANES];

  always_comb begin
    for (int i = 0; i < lcan_pkg::NUM_LANES; i++) begin
      prod[i] = rng[i] * cfg.contrast;
      shifted[i] = RW'({tex[i], 15'b0});
      rem2[i] = {rem[i][RW-2:0], 1'b0};
      amb[i] = (cfg.ambient[i] > lcan_pkg::ONE_Q16) ? lcan_pkg::ONE_Q16 : cfg.ambient[i];
      blend[i] = {17'b0, quot[i]} * {16'b0, lcan_pkg::ONE_Q16 - amb[i]};
      shade[i] = sat[i] ? lcan_pkg::ONE_Q16 : (amb[i] + blend[i][32:16]);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lcan_pkg::ST_IDLE: begin
        if (avail) begin
          state_next = lcan_pkg::ST_MUL;
        end
      end
      lcan_pkg::ST_MUL: state_next = lcan_pkg::ST_CMP;
      lcan_pkg::ST_CMP: state_next = lcan_pkg::ST_DIV;
      lcan_pkg::ST_DIV: begin
        if (cnt == CW'(lcan_pkg::QUOT_BITS - 1)) begin
          state_next = lcan_pkg::ST_FIN;
        end
      end
      lcan_pkg::ST_FIN: begin
        if (!out_valid || out_ch.ready) begin
          state_next = lcan_pkg::ST_IDLE;
        end
      end
      default: state_next = lcan_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop = (state == lcan_pkg::ST_IDLE) && avail;
    load_out = (state == lcan_pkg::ST_FIN) && (!out_valid || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcan_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lcan_pkg::ST_IDLE: begin
        for (int i = 0; i < lcan_pkg::NUM_LANES; i++) begin
          rng[i] <= pop_data[2*i*TEXEL_BITS +: TEXEL_BITS];
          tex[i] <= pop_data[(2*i+1)*TEXEL_BITS +: TEXEL_BITS];
        end
      end
      lcan_pkg::ST_MUL: begin
        for (int i = 0; i < lcan_pkg::NUM_LANES; i++) begin
          if (prod[i] == '0) begin
            scale[i] <= SW'({cfg.contrast, 16'b0});
          end else begin
            scale[i] <= SW'(prod[i]);
          end
        end
      end
      lcan_pkg::ST_CMP: begin
        cnt <= '0;
        for (int i = 0; i < lcan_pkg::NUM_LANES; i++) begin
          rem[i] <= shifted[i];
          sat[i] <= shifted[i] >= {1'b0, scale[i]};
          quot[i] <= '0;
        end
      end
      lcan_pkg::ST_DIV: begin
        cnt <= cnt + CW'(1);
        for (int i = 0; i < lcan_pkg::NUM_LANES; i++) begin
          if (rem2[i] >= {1'b0, scale[i]}) begin
            rem[i] <= rem2[i] - {1'b0, scale[i]};
            quot[i] <= {quot[i][lcan_pkg::QUOT_BITS-2:0], 1'b1};
          end else begin
            rem[i] <= rem2[i];
            quot[i] <= {quot[i][lcan_pkg::QUOT_BITS-2:0], 1'b0};
          end
        end
      end
      lcan_pkg::ST_FIN: begin
        if (load_out) begin
          for (int i = 0; i < lcan_pkg::NUM_LANES; i++) begin
            result[i] <= shade[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid = out_valid;
  assign out_ch.red_out = result[0];
  assign out_ch.green_out = result[1];
  assign out_ch.blue_out = result[2];

endmodule
`default_nettype wire

### sv/lightmap_contrast_ambient_normalize.sv
// Channel   Direction  Payload
// in_ch     sink       operation, texel_valid, red_in, green_in, blue_in
// out_ch    source     red_out, green_out, blue_out
// cfg_*     write      cfg_index selects the register, cfg_data carries the value
//
// Clear and measure transactions finish in the cycle they are accepted.
// The back end takes a valid transform through a load, a multiply, a compare,
// 16 restoring divide steps run side by side by the three lanes' dividers, and a blend.
// A two-entry queue sits between front and back, so input stalls only when it is full.
// Reset is synchronous; it resets the trackers, the queue and the registers (contrast to 26214, ambients to 0).
`default_nettype none
module lightmap_contrast_ambient_normalize #(
  parameter int TEXEL_BITS = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  lcan_in_if.sink                                    in_ch,
  lcan_out_if.source                                 out_ch,
  input  wire logic                                  cfg_we,
  input  wire logic [lcan_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [lcan_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  lcan_pkg::cfg_t            cfg;
  logic                      push;
  logic [6*TEXEL_BITS-1:0]   push_data;
  logic                      full;
  logic                      pop;
  logic                      avail;
  logic [6*TEXEL_BITS-1:0]   pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.contrast <= lcan_pkg::CONTRAST_RESET;
      cfg.ambient <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lcan_pkg::REG_CONTRAST: cfg.contrast <= cfg_data[15:0];
        lcan_pkg::REG_AMBIENT_RED: cfg.ambient[0] <= cfg_data;
        lcan_pkg::REG_AMBIENT_GREEN: cfg.ambient[1] <= cfg_data;
        lcan_pkg::REG_AMBIENT_BLUE: cfg.ambient[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lcan_front #(.TEXEL_BITS(TEXEL_BITS)) u_front (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .full(full),
    .push(push),
    .push_data(push_data)
  );

  lcan_fifo #(.WIDTH(6*TEXEL_BITS)) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(full),
    .pop(pop),
    .avail(avail),
    .pop_data(pop_data)
  );

  lcan_back #(.TEXEL_BITS(TEXEL_BITS)) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .avail(avail),
    .pop_data(pop_data),
    .pop(pop),
    .out_ch(out_ch)
  );

endmodule
`default_nettype wire
